>>> sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and the sequencer state type.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int EXP_WIDTH_DEF = 32;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int BASE_W        = 32;
    localparam int EXPI_W        = 32;
    localparam int RES_W         = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RBASE,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_DONE
    } t_state;

endpackage

>>> sv/modexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the operand and result transfers.
// ----------------------------------------------------------------------------
interface modexp_in_if;
    logic                             valid;
    logic                             ready;
    logic [modexp_pkg::BASE_W-1:0]    base_value;
    logic [modexp_pkg::EXPI_W-1:0]    exponent;
    modport source (output valid, base_value, exponent, input ready);
    modport sink   (input valid, base_value, exponent, output ready);
endinterface

interface modexp_out_if;
    logic                            valid;
    logic                            ready;
    logic [modexp_pkg::RES_W-1:0]    result;
    logic                            error;
    modport source (output valid, result, error, input ready);
    modport sink   (input valid, result, error, output ready);
endinterface

>>> sv/modular_exponentiation_core.sv
// From operand transfer to result valid: a base reduction over the wider of
// BASE_W and MOD_WIDTH bits, then per exponent bit one square over MOD_WIDTH
// bits plus one more multiply if the bit is set. A zero modulus goes straight
// to the result with the error flag set. One item at a time: the next operand
// is taken at the earliest in the cycle after the result transfer.
// Sync active-low reset returns to idle, modulus set to 1.
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Right-to-left binary square-and-multiply with an interleaved mod multiplier.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    modexp_in_if.sink            in_ch,
    modexp_out_if.source         out_ch
);
    // Multiply step: Horner over the multiplier bits, MSB first:
    //   p = 2p (mod m); if bit: p = p + a (mod m)
    // both done in one cycle per bit with two conditional subtracts.
    // Base reduce runs MPW bits (base times 1 mod m); squares and
    // accumulate multiplies run MOD_WIDTH bits with the operand left-aligned.
    localparam int W   = MOD_WIDTH;
    localparam int MPW = (modexp_pkg::BASE_W > W) ? modexp_pkg::BASE_W : W;
    localparam int CW  = $clog2(MPW);
    localparam int EW  = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

    modexp_pkg::t_state r_state, n_state;
    logic [W-1:0]   r_mod;
    logic [W-1:0]   r_acc, n_acc, r_sq, n_sq;
    logic [EXP_WIDTH-1:0] r_exp, n_exp;
    logic [EW-1:0]  r_ecnt, n_ecnt;
    logic [MPW-1:0] r_mplr, n_mplr;   // multiplier bits, shifted out MSB first
    logic [W-1:0]   r_mcnd, n_mcnd;   // multiplicand
    logic [W-1:0]   r_prod, n_prod;
    logic [CW-1:0]  r_bcnt, n_bcnt;
    logic           r_err, n_err;
    logic [W-1:0]   r_res, n_res;

    // one step of the shared unit
    logic [W:0] dbl, dbl_r, sum, sum_r;
    logic [W-1:0] step_out;
    always_comb begin
        dbl   = {r_prod, 1'b0};
        dbl_r = (dbl >= {1'b0, r_mod}) ? dbl - {1'b0, r_mod} : dbl;
        sum   = dbl_r + {1'b0, r_mcnd};
        sum_r = (sum >= {1'b0, r_mod}) ? sum - {1'b0, r_mod} : sum;
        step_out = r_mplr[MPW-1] ? sum_r[W-1:0] : dbl_r[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= modexp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc <= n_acc; r_sq <= n_sq; r_exp <= n_exp; r_ecnt <= n_ecnt;
        r_mplr <= n_mplr; r_mcnd <= n_mcnd; r_prod <= n_prod; r_bcnt <= n_bcnt;
        r_err <= n_err; r_res <= n_res;
    end

    // base reduce walks the whole base word, the multiplies one modulus word
    logic mul_last;
    assign mul_last = (r_state == modexp_pkg::ST_RBASE) ? (r_bcnt == CW'(MPW - 1))
                                                         : (r_bcnt == CW'(W - 1));

    always_comb begin
        n_state = r_state;
        n_acc = r_acc; n_sq = r_sq; n_exp = r_exp; n_ecnt = r_ecnt;
        n_mplr = r_mplr; n_mcnd = r_mcnd; n_prod = r_prod; n_bcnt = r_bcnt;
        n_err = r_err; n_res = r_res;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        unique case (r_state) inside
            modexp_pkg::ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid) begin
                    n_exp  = EXP_WIDTH'(in_ch.exponent);
                    n_ecnt = '0;
                    n_bcnt = '0;
                    n_prod = '0;
                    // 1 mod m: zero when m is one
                    n_acc  = (r_mod == W'(1)) ? '0 : W'(1);
                    n_err  = (r_mod == '0);
                    if (r_mod == '0) begin
                        n_res   = '0;
                        n_state = modexp_pkg::ST_DONE;
                    end else begin
                        n_mplr  = MPW'(in_ch.base_value);
                        n_mcnd  = (r_mod == W'(1)) ? '0 : W'(1);
                        n_state = modexp_pkg::ST_RBASE;
                    end
                end
            end
            modexp_pkg::ST_RBASE, modexp_pkg::ST_MUL_ACC, modexp_pkg::ST_MUL_SQ: begin
                n_prod = step_out;
                n_mplr = {r_mplr[MPW-2:0], 1'b0};
                n_bcnt = r_bcnt + CW'(1);
                if (mul_last) begin
                    n_bcnt = '0;
                    n_prod = '0;
                    if (r_state == modexp_pkg::ST_MUL_ACC) begin
                        n_acc = step_out;
                    end else begin
                        n_sq = step_out;
                    end
                    if (r_state == modexp_pkg::ST_MUL_SQ) begin
                        n_exp  = r_exp >> 1;
                        n_ecnt = r_ecnt + EW'(1);
                    end
                    // choose next operation; after a reduce or a square the
                    // new running power is step_out
                    if (r_state == modexp_pkg::ST_MUL_SQ &&
                        r_ecnt == EW'(EXP_WIDTH - 1)) begin
                        n_res   = r_acc;
                        n_state = modexp_pkg::ST_DONE;
                    end else if (r_state == modexp_pkg::ST_MUL_ACC) begin
                        n_mplr  = MPW'(r_sq) << (MPW - W);
                        n_mcnd  = r_sq;
                        n_state = modexp_pkg::ST_MUL_SQ;
                    end else if ((r_state == modexp_pkg::ST_RBASE) ? r_exp[0]
                                                                   : r_exp[1]) begin
                        n_mplr  = MPW'(step_out) << (MPW - W);
                        n_mcnd  = r_acc;
                        n_state = modexp_pkg::ST_MUL_ACC;
                    end else begin
                        n_mplr  = MPW'(step_out) << (MPW - W);
                        n_mcnd  = step_out;
                        n_state = modexp_pkg::ST_MUL_SQ;
                    end
                end
            end
            modexp_pkg::ST_DONE: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready) begin
                    n_state = modexp_pkg::ST_IDLE;
                end
            end
            default: n_state = modexp_pkg::ST_IDLE;
        endcase
    end

    assign out_ch.result = modexp_pkg::RES_W'(r_res);
    assign out_ch.error  = r_err;

`ifndef SYNTHESIS
    a_err_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.error) |-> (out_ch.result == '0))
        else $error("error result not zero");
    a_res_lt_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.error) |-> (r_res < r_mod))
        else $error("result not reduced");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("accepting while result pending");
`endif

endmodule

>>> dv/modular_exponentiation_core_tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Drives base/exponent operands through the input channel and checks every
// result against a built-in square-and-multiply predictor or, for directed rows
// marked known, a given value. The run covers several modulus settings and
// several sender/receiver idle mixes.
module modular_exponentiation_core_tb;

    typedef struct {
        logic [31:0] modv;
        logic [31:0] base_v;
        logic [31:0] expo;
        bit          known;
        logic [31:0] res;
        bit          err;
    } t_row;

    typedef struct {
        logic [31:0] res;
        bit          err;
    } t_modexp_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    modexp_in_if  in_ch ();
    modexp_out_if out_ch ();

    modular_exponentiation_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_modexp_res pending_results[$];
    logic [31:0] cur_modulus = 32'd1;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          sent_cnt = 0;
    int          got_cnt  = 0;

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.base_value = '0;
        in_ch.exponent   = '0;
        out_ch.ready     = 1'b0;
    end

    // right-to-left square-and-multiply, zero modulus flags an error
    function automatic t_modexp_res pow_mod(logic [31:0] b, logic [31:0] e,
                                            logic [31:0] m);
        t_modexp_res r;
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned mm;
        mm = m;
        if (m == 0) begin
            r.res = '0;
            r.err = 1'b1;
            return r;
        end
        sq  = b % mm;
        acc = 1 % mm;
        for (int i = 0; i < 32; i++) begin
            if (e[i]) acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        r.res = acc[31:0];
        r.err = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, got_cnt);
    endtask

    // result side: random stalls, check each transfer against the oldest entry
    always @(posedge i_clk) begin
        t_modexp_res want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_cnt++;
                if (pending_results.size() == 0) begin
                    report("unexpected result", out_ch.result, 32'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.result !== want.res) report("result", out_ch.result, want.res);
                    if (out_ch.error !== want.err)
                        report("error", 32'(out_ch.error), 32'(want.err));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // sender goes quiet, then waits for every expected result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register writes only with the core idle
    task automatic set_modulus(logic [31:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_modulus = v;
    endtask

    // one operand transfer; expectation queued at the accepting edge
    task automatic send(logic [31:0] b, logic [31:0] e, bit known = 0,
                        logic [31:0] kres = 0, bit kerr = 0);
        t_modexp_res want;
        if ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.base_value <= b;
        in_ch.exponent   <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        want = pow_mod(b, e, cur_modulus);
        if (known) begin
            want.res = kres;
            want.err = kerr;
        end
        pending_results = {pending_results, want};
        sent_cnt++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return '0;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    t_row directed[] = '{
        // modulus stays at its reset value of one: everything reduces to 0
        '{32'd1,        32'd5,        32'd3,        1, 32'd0, 0},
        '{32'd1,        32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'd0, 0},
        '{32'd1,        32'd7,        32'd0,        1, 32'd0, 0},
        // zero modulus raises the error flag
        '{32'd0,        32'd0,        32'd0,        1, 32'd0, 1},
        '{32'd0,        32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'd0, 1},
        // zero exponent gives one; then further cases mod 13
        '{32'd13,       32'd0,        32'd0,        1, 32'd1, 0},
        '{32'd13,       32'hFFFFFFFF, 32'd0,        1, 32'd1, 0},
        '{32'd13,       32'd0,        32'd5,        1, 32'd0, 0},
        '{32'd13,       32'd2,        32'd10,       0, 32'd0, 0},
        '{32'd13,       32'd26,       32'd7,        1, 32'd0, 0},
        // Fermat: 3^96 mod 97 = 1
        '{32'd97,       32'd3,        32'd96,       1, 32'd1, 0},
        '{32'd97,       32'h80000000, 32'h80000000, 0, 32'd0, 0},
        '{32'd97,       32'hFFFFFFFF, 32'd1,        0, 32'd0, 0},
        '{32'hFFFFFFFF, 32'd0,        32'd0,        1, 32'd1, 0},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd1,        1, 32'hFFFFFFFE, 0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'd0, 0},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 0, 32'd0, 0},
        '{32'hFFFFFFFB, 32'h12345678, 32'hAAAAAAAA, 0, 32'd0, 0},
        '{32'hFFFFFFFB, 32'h87654321, 32'h55555555, 0, 32'd0, 0},
        '{32'd2,        32'd3,        32'd12345,    1, 32'd1, 0}
    };

    initial begin
        logic [31:0] mod_plan[5];
        int          idle_plan[5];
        int          stall_plan[5];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].modv != cur_modulus) set_modulus(directed[i].modv);
            send(directed[i].base_v, directed[i].expo, directed[i].known,
                 directed[i].res, directed[i].err);
        end

        mod_plan   = '{$urandom | 32'h1, 32'hFFFFFFFF, $urandom_range(2, 20),
                       $urandom_range(3, 65535), $urandom};
        idle_plan  = '{0, 71, 0, 23, 0};
        stall_plan = '{0, 0, 71, 23, 0};
        for (int p = 0; p < 5; p++) begin
            set_modulus(mod_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            for (int k = 0; k < 50; k++) begin
                // hold off once until the core has emptied out
                if (p == 2 && k == 25) begin
                    drain();
                end
                send(rand_word(), rand_word());
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d operand transfers and %0d result transfers", sent_cnt, got_cnt);
        $display("over moduli 1, 0, small, mid and all-ones, with mixed idle and stall.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
